[sv/dft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-first traversal package
// Shared sizes, field codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package dft_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int DEPTH_W      = IDX_W + 1;
    localparam int VERT_W       = 7;
    localparam int S_TDATA_W    = ((2 * VERT_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((VERT_W + 7) / 8) * 8;

    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_WALK = 1'b1;

    localparam logic [VERT_W-1:0] VERTEX_COUNT_RESET = VERT_W'(64);

    typedef struct packed {
        logic capture;
        logic edge_rd;
        logic edge_wr;
        logic start;
        logic top_rd;
        logic push;
        logic pop_rd;
        logic load_top;
        logic emit;
        logic emit_last;
        logic finish;
    } dft_cmd_t;

    typedef struct packed {
        logic cand_found;
        logic depth_one;
        logic depth_zero;
        logic out_free;
    } dft_status_t;

endpackage

[sv/dft_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-first traversal datapath
// Adjacency store, path stack, visited marks, neighbour search, output register.
// ----------------------------------------------------------------------------
module dft_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [dft_pkg::VERT_W-1:0]       in_from,
    input  logic [dft_pkg::VERT_W-1:0]       in_to,
    input  logic [dft_pkg::VERT_W-1:0]       vertex_count,
    input  dft_pkg::dft_cmd_t                cmd,
    output dft_pkg::dft_status_t             status,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [dft_pkg::VERT_W-1:0]       out_vertex,
    output logic                             out_last
);

    localparam int NV = dft_pkg::MAX_VERTICES;
    localparam int IW = dft_pkg::IDX_W;
    localparam int DW = dft_pkg::DEPTH_W;
    localparam int VW = dft_pkg::VERT_W;

    logic [NV-1:0] adj_mem [NV];
    logic [NV-1:0] adj_valid_reg;
    logic [NV-1:0] adj_q_reg;
    logic          adj_q_valid_reg;
    logic [IW-1:0] stack_mem [NV];
    logic [IW-1:0] stack_q_reg;

    logic [VW-1:0] from_reg;
    logic [VW-1:0] to_reg;
    logic [NV-1:0] visited_reg;
    logic [DW-1:0] depth_reg;
    logic [IW-1:0] top_reg;
    logic [VW-1:0] pend_reg;
    logic [NV-1:0] range_reg;
    logic          out_valid_reg;
    logic [VW-1:0] out_vertex_reg;
    logic          out_last_reg;

    logic [VW-1:0] from_m1;
    logic [VW-1:0] to_m1;
    logic [IW-1:0] from_idx;
    logic [IW-1:0] to_idx;
    logic          edge_ok;
    logic [IW-1:0] adj_addr;
    logic [NV-1:0] row_eff;
    logic [NV-1:0] cand;
    logic [NV-1:0] iso;
    logic [IW-1:0] nxt_idx;
    logic [VW-1:0] nxt_vtx;
    logic [VW-1:0] n_sat;
    logic [NV-1:0] range_next;
    logic [DW-1:0] depth_m2;
    logic [IW-1:0] stack_wr_addr;
    logic [IW-1:0] stack_wr_data;

    assign from_m1  = from_reg - VW'(1);
    assign to_m1    = to_reg - VW'(1);
    assign from_idx = from_m1[IW-1:0];
    assign to_idx   = to_m1[IW-1:0];
    assign edge_ok  = (from_reg != '0) && (from_reg <= VW'(NV))
                   && (to_reg != '0) && (to_reg <= VW'(NV));
    assign adj_addr = cmd.edge_rd ? from_idx : top_reg;

    assign row_eff = adj_q_valid_reg ? adj_q_reg : '0;
    assign cand    = row_eff & ~visited_reg & range_reg;
    assign iso     = cand & (~cand + NV'(1));

    always_comb
    begin
        nxt_idx = '0;
        for (int i = 0; i < NV; i++)
        begin
            if (iso[i])
            begin
                nxt_idx = nxt_idx | IW'(i);
            end
        end
    end

    assign nxt_vtx = VW'(nxt_idx) + VW'(1);
    assign n_sat   = (vertex_count > VW'(NV)) ? VW'(NV) : vertex_count;

    always_comb
    begin
        for (int i = 0; i < NV; i++)
        begin
            range_next[i] = (VW'(i) < n_sat);
        end
    end

    assign depth_m2      = depth_reg - DW'(2);
    assign stack_wr_addr = cmd.start ? '0 : depth_reg[IW-1:0];
    assign stack_wr_data = cmd.start ? '0 : nxt_idx;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.edge_wr && edge_ok)
        begin
            adj_mem[from_idx] <= row_eff | (NV'(1) << to_idx);
        end
        if (cmd.edge_rd || cmd.top_rd)
        begin
            adj_q_reg       <= adj_mem[adj_addr];
            adj_q_valid_reg <= adj_valid_reg[adj_addr];
        end
        if (cmd.start || cmd.push)
        begin
            stack_mem[stack_wr_addr] <= stack_wr_data;
        end
        if (cmd.pop_rd)
        begin
            stack_q_reg <= stack_mem[depth_m2[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_valid_reg <= '0;
            visited_reg   <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.edge_wr && edge_ok)
            begin
                adj_valid_reg[from_idx] <= 1'b1;
            end
            priority if (cmd.start)
            begin
                visited_reg <= NV'(1);
                depth_reg   <= DW'(1);
            end
            else if (cmd.push)
            begin
                visited_reg <= visited_reg | iso;
                depth_reg   <= depth_reg + DW'(1);
            end
            else if (cmd.pop_rd)
            begin
                depth_reg <= depth_reg - DW'(1);
            end
            else if (cmd.finish)
            begin
                visited_reg <= '0;
                depth_reg   <= '0;
            end
            else
            begin
                depth_reg <= depth_reg;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            from_reg <= in_from;
            to_reg   <= in_to;
        end
        priority if (cmd.start)
        begin
            top_reg   <= '0;
            pend_reg  <= VW'(1);
            range_reg <= range_next;
        end
        else if (cmd.push)
        begin
            top_reg  <= nxt_idx;
            pend_reg <= nxt_vtx;
        end
        else if (cmd.load_top)
        begin
            top_reg <= stack_q_reg;
        end
        else
        begin
            top_reg <= top_reg;
        end
        if (cmd.emit)
        begin
            out_vertex_reg <= pend_reg;
            out_last_reg   <= cmd.emit_last;
        end
    end

    assign status.cand_found = |cand;
    assign status.depth_one  = (depth_reg == DW'(1));
    assign status.depth_zero = (depth_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_vertex = out_vertex_reg;
    assign out_last   = out_last_reg;

endmodule

[sv/dft_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-first traversal controller
// Sequences edge writes and the push/pop walk over the datapath.
// ----------------------------------------------------------------------------
module dft_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_mode,
    output logic                 in_ready,
    input  dft_pkg::dft_status_t status,
    output dft_pkg::dft_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_RD,
        ST_EDGE_WR,
        ST_START,
        ST_ROW_RD,
        ST_EVAL,
        ST_LOAD,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (in_mode == dft_pkg::MODE_WALK) ? ST_START : ST_EDGE_RD;
                end
            end
            ST_EDGE_RD:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = ST_EDGE_WR;
            end
            ST_EDGE_WR:
            begin
                cmd.edge_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = ST_ROW_RD;
            end
            ST_ROW_RD:
            begin
                cmd.top_rd = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                priority if (status.cand_found)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.push   = 1'b1;
                        state_next = ST_ROW_RD;
                    end
                end
                else if (status.depth_one)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load_top = 1'b1;
                state_next   = ST_ROW_RD;
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.finish    = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/depth_first_traversal_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-first traversal core
// Adjacency bit matrix with an iterative depth-first walk from vertex 1.
// ----------------------------------------------------------------------------
// Input channel (s_*): one request per transfer. s_tuser is the mode: 0 stores
// the directed edge s_tdata[6:0] -> s_tdata[13:7], 1 starts a walk from vertex 1.
// Output channel (m_*): one visited vertex per transfer in m_tdata[6:0], in
// depth-first order; m_tlast marks the final vertex of a walk.
// Configuration: cfg_wr_en/cfg_wr_data write vertex_count (reset 64), the
// number of vertices scanned for successors; write only while idle.
// An edge request reads the adjacency row of its source, then writes it back.
// A walk reads the adjacency row, then searches, per visited vertex, and reads
// the stack, reloads the top and reads the row per pop, since the reads of the
// adjacency and stack memories are registered.
// One request is worked on at a time; s_tready is high only when idle.
// Each vertex is held back until the next one is found or the walk ends,
// to set m_tlast.
// Reset clears the adjacency matrix at once through per-row valid bits.
// When the receiver stalls the walk holds with its result in the output
// register and resumes when it is taken.
// ----------------------------------------------------------------------------
module depth_first_traversal_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dft_pkg::S_TDATA_W-1:0]   s_tdata,   // from_vertex, to_vertex
    input  logic                            s_tuser,   // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dft_pkg::M_TDATA_W-1:0]   m_tdata,   // vertex
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [dft_pkg::VERT_W-1:0]      cfg_wr_data
);

    localparam int VW = dft_pkg::VERT_W;

    logic [VW-1:0]        vertex_count_reg;
    dft_pkg::dft_cmd_t    cmd;
    dft_pkg::dft_status_t status;
    logic [VW-1:0]        out_vertex;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= dft_pkg::VERTEX_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            vertex_count_reg <= cfg_wr_data;
        end
    end

    dft_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dft_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_from      (s_tdata[VW-1:0]),
        .in_to        (s_tdata[2*VW-1:VW]),
        .vertex_count (vertex_count_reg),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_vertex   (out_vertex),
        .out_last     (m_tlast)
    );

    assign m_tdata = {{(dft_pkg::M_TDATA_W - VW){1'b0}}, out_vertex};

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while the previous one is in progress");

    a_idle_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> status.depth_zero)
        else $error("stack not empty while idle");

    a_vertex_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_vertex != '0))
        else $error("vertex zero presented on output");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-first traversal core testbench
// Loads arcs into the adjacency matrix and starts walks from vertex 1 under a range
// of scan bounds. A model of the walk predicts each visited vertex and its last
// flag unless a directed row fixes them; both stream sides stall in random bursts.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 22;
    localparam int DIRECTED_ROWS  = 22;

    typedef struct packed {
        logic [dft_pkg::VERT_W-1:0] vertex;
        logic                       last;
    } visit_t;

    typedef struct packed {
        logic                       set_cfg;
        logic [dft_pkg::VERT_W-1:0] cfg_value;
        logic                       mode;
        logic [dft_pkg::VERT_W-1:0] from_v;
        logic [dft_pkg::VERT_W-1:0] to_v;
        logic                       typed;
        logic [dft_pkg::VERT_W-1:0] t_vertex;
        logic                       t_last;
    } row_t;

    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b0, 7'd0,   dft_pkg::MODE_WALK, 7'd0,   7'd0,   1'b1, 7'd1, 1'b1},
        '{1'b0, 7'd0,   dft_pkg::MODE_EDGE, 7'd0,   7'd5,   1'b0, 7'd0, 1'b0},
        '{1'b0, 7'd0,   dft_pkg::MODE_EDGE, 7'd1,   7'd0,   1'b0, 7'd0, 1'b0},
        '{1'b0, 7'd0,   dft_pkg::MODE_EDGE, 7'd1,   7'd127, 1'b0, 7'd0, 1'b0},
        '{1'b0, 7'd0,   dft_pkg::MODE_EDGE, 7'd127, 7'd1,   1'b0, 7'd0, 1'b0},
        '{1'b0, 7'd0,   dft_pkg::MODE_EDGE, 7'd65,  7'd2,   1'b0, 7'd0, 1'b0},
        '{1'b0, 7'd0,   dft_pkg::MODE_WALK, 7'd0,   7'd0,   1'b1, 7'd1, 1'b1},
        '{1'b0, 7'd0,   dft_pkg::MODE_EDGE, 7'd1,   7'd64,  1'b0, 7'd0, 1'b0},
        '{1'b0, 7'd0,   dft_pkg::MODE_EDGE, 7'd64,  7'd2,   1'b0, 7'd0, 1'b0},
        '{1'b0, 7'd0,   dft_pkg::MODE_EDGE, 7'd2,   7'd1,   1'b0, 7'd0, 1'b0},
        '{1'b0, 7'd0,   dft_pkg::MODE_EDGE, 7'd1,   7'd64,  1'b0, 7'd0, 1'b0},
        '{1'b0, 7'd0,   dft_pkg::MODE_EDGE, 7'd1,   7'd3,   1'b0, 7'd0, 1'b0},
        '{1'b0, 7'd0,   dft_pkg::MODE_WALK, 7'd127, 7'd127, 1'b0, 7'd0, 1'b0},
        '{1'b1, 7'd0,   dft_pkg::MODE_WALK, 7'd5,   7'd9,   1'b1, 7'd1, 1'b1},
        '{1'b1, 7'd127, dft_pkg::MODE_WALK, 7'd0,   7'd0,   1'b0, 7'd0, 1'b0},
        '{1'b1, 7'd2,   dft_pkg::MODE_WALK, 7'd0,   7'd0,   1'b0, 7'd0, 1'b0},
        '{1'b0, 7'd0,   dft_pkg::MODE_EDGE, 7'd1,   7'd2,   1'b0, 7'd0, 1'b0},
        '{1'b0, 7'd0,   dft_pkg::MODE_WALK, 7'd0,   7'd0,   1'b0, 7'd0, 1'b0},
        '{1'b1, 7'd64,  dft_pkg::MODE_EDGE, 7'd64,  7'd64,  1'b0, 7'd0, 1'b0},
        '{1'b0, 7'd0,   dft_pkg::MODE_EDGE, 7'd1,   7'd1,   1'b0, 7'd0, 1'b0},
        '{1'b0, 7'd0,   dft_pkg::MODE_WALK, 7'd0,   7'd0,   1'b0, 7'd0, 1'b0},
        '{1'b1, 7'd1,   dft_pkg::MODE_WALK, 7'd0,   7'd0,   1'b0, 7'd0, 1'b0}
    };

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [dft_pkg::S_TDATA_W-1:0] s_tdata;    // from_vertex, to_vertex
    logic                          s_tuser;    // mode
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [dft_pkg::M_TDATA_W-1:0] m_tdata;    // vertex
    logic                          m_tlast;
    logic                          cfg_wr_en;
    logic [dft_pkg::VERT_W-1:0]    cfg_wr_data;

    logic [dft_pkg::MAX_VERTICES-1:0] arc_rows [dft_pkg::MAX_VERTICES];
    logic [dft_pkg::VERT_W-1:0]       scan_count;
    visit_t                           pending_visits [$];
    int                               fail_count     = 0;
    int                               visits_checked = 0;
    int                               arcs_sent      = 0;
    int                               walks_sent     = 0;
    int                               ready_hold     = 0;
    int                               idle_cycles    = 0;
    bit                               stall_enable   = 1'b1;

    depth_first_traversal_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void store_arc(logic [dft_pkg::VERT_W-1:0] from_v,
                                      logic [dft_pkg::VERT_W-1:0] to_v);
        if (from_v >= 1 && from_v <= dft_pkg::MAX_VERTICES
            && to_v >= 1 && to_v <= dft_pkg::MAX_VERTICES)
        begin
            arc_rows[from_v - 1][to_v - 1] = 1'b1;
        end
    endfunction

    function automatic void predict_walk();
        logic [dft_pkg::MAX_VERTICES-1:0] seen;
        logic [dft_pkg::MAX_VERTICES-1:0] cand;
        logic [dft_pkg::MAX_VERTICES-1:0] scan_mask;
        logic [dft_pkg::IDX_W-1:0]        path [dft_pkg::MAX_VERTICES];
        logic [dft_pkg::VERT_W-1:0]       held;
        int                               depth;
        int                               bound;
        int                               nxt;
        bound     = (scan_count > dft_pkg::MAX_VERTICES) ? dft_pkg::MAX_VERTICES
                                                         : int'(scan_count);
        scan_mask = (bound >= dft_pkg::MAX_VERTICES) ? '1 : ((64'd1 << bound) - 64'd1);
        seen      = 64'd1;
        path[0]   = '0;
        depth     = 1;
        held      = dft_pkg::VERT_W'(1);
        while (depth > 0)
        begin
            cand = arc_rows[path[depth - 1]] & ~seen & scan_mask;
            if (cand == '0)
            begin
                depth--;
            end
            else
            begin
                nxt = 0;
                while (cand[nxt] == 1'b0)
                begin
                    nxt++;
                end
                seen[nxt] = 1'b1;
                // hold the newest vertex back until the walk shows whether it is last
                pending_visits.push_back('{held, 1'b0});
                held        = dft_pkg::VERT_W'(nxt + 1);
                path[depth] = dft_pkg::IDX_W'(nxt);
                depth++;
            end
        end
        pending_visits.push_back('{held, 1'b1});
    endfunction

    task automatic send_request(logic mode, logic [dft_pkg::VERT_W-1:0] from_v,
                                logic [dft_pkg::VERT_W-1:0] to_v);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= dft_pkg::S_TDATA_W'({to_v, from_v});
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    task automatic issue_request(logic mode, logic [dft_pkg::VERT_W-1:0] from_v,
                                 logic [dft_pkg::VERT_W-1:0] to_v);
        send_request(mode, from_v, to_v);
        if (mode == dft_pkg::MODE_EDGE)
        begin
            store_arc(from_v, to_v);
            arcs_sent++;
        end
        else
        begin
            predict_walk();
            walks_sent++;
        end
    endtask

    task automatic sender_gap();
        if (stall_enable && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_visits.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_vertex_count(logic [dft_pkg::VERT_W-1:0] value);
        drain_results();
        // let a trailing arc request finish before the write
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        scan_count = value;
    endtask

    always @(posedge clk)
    begin
        if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end
        else if (stall_enable && $urandom_range(0, 7) == 0)
        begin
            ready_hold <= $urandom_range(0, 18);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        visit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_visits.size() == 0)
            begin
                $error("unexpected result: vertex %0d last %0b",
                       m_tdata[dft_pkg::VERT_W-1:0], m_tlast);
                fail_count++;
            end
            else
            begin
                want = pending_visits.pop_front();
                if (m_tdata[dft_pkg::VERT_W-1:0] !== want.vertex)
                begin
                    $error("vertex: expected %0d, actual %0d", want.vertex,
                           m_tdata[dft_pkg::VERT_W-1:0]);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, m_tlast);
                    fail_count++;
                end
                visits_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int hi;
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= dft_pkg::MODE_EDGE;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        scan_count  = dft_pkg::VERTEX_COUNT_RESET;
        foreach (arc_rows[i])
        begin
            arc_rows[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].set_cfg)
            begin
                write_vertex_count(DIRECTED[i].cfg_value);
            end
            if (DIRECTED[i].typed)
            begin
                send_request(DIRECTED[i].mode, DIRECTED[i].from_v, DIRECTED[i].to_v);
                pending_visits.push_back('{DIRECTED[i].t_vertex, DIRECTED[i].t_last});
                walks_sent++;
            end
            else
            begin
                issue_request(DIRECTED[i].mode, DIRECTED[i].from_v, DIRECTED[i].to_v);
            end
            sender_gap();
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       write_vertex_count(dft_pkg::VERT_W'($urandom_range(8, 12)));
                1:       write_vertex_count(dft_pkg::VERT_W'(64));
                2:       write_vertex_count(dft_pkg::VERT_W'($urandom_range(65, 127)));
                3:       write_vertex_count(dft_pkg::VERT_W'($urandom_range(1, 7)));
                default: write_vertex_count(dft_pkg::VERT_W'(64));
            endcase
            stall_enable = (phase != PHASES - 1);
            hi = (phase == 0) ? 10 : (phase == 1) ? 24 : dft_pkg::MAX_VERTICES;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 1 && k == PHASE_ITEMS / 2)
                begin
                    drain_results();
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    issue_request(dft_pkg::MODE_WALK,
                                  dft_pkg::VERT_W'($urandom_range(0, 127)),
                                  dft_pkg::VERT_W'($urandom_range(0, 127)));
                end
                else if ($urandom_range(0, 6) == 0)
                begin
                    issue_request(dft_pkg::MODE_EDGE,
                                  dft_pkg::VERT_W'($urandom_range(0, 127)),
                                  dft_pkg::VERT_W'($urandom_range(0, 127)));
                end
                else
                begin
                    issue_request(dft_pkg::MODE_EDGE,
                                  dft_pkg::VERT_W'($urandom_range(1, hi)),
                                  dft_pkg::VERT_W'($urandom_range(1, hi)));
                end
                sender_gap();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d arc requests and %0d walks, %0d visited vertices checked,",
                 arcs_sent, walks_sent, visits_checked);
        $display("with scan bounds from 0 to 127 and random stalls on both stream sides.");
        if (fail_count == 0 && pending_visits.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
